>>> rtl/sph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sph_pkg: shared definitions for the spatial pyramid histogram
// Sizes, codes, payload structs, controller state and the control bundle
// that passes between the controller and the datapath.
// ----------------------------------------------------------------------------
package sph_pkg;

    // Build-time sizing.
    localparam int MAX_LEVEL  = 3;
    localparam int WORDS      = 1024;
    localparam int COUNT_BITS = 16;

    // Fixed field widths.
    localparam int OP_W        = 2;
    localparam int POS_W       = 12;
    localparam int WORD_W      = 10;
    localparam int CELL_REQ_W  = 7;
    localparam int OUT_W       = 16;
    localparam int NONEMPTY_W  = 7;
    localparam int LEVELS_W    = 2;
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 2;

    // Derived sizes.
    localparam int CELLS     = ((1 << (2 * (MAX_LEVEL + 1))) - 1) / 3;
    localparam int BIN_DEPTH = CELLS * WORDS;
    localparam int BIN_AW    = (BIN_DEPTH > 1) ? $clog2(BIN_DEPTH) : 1;
    localparam int TOT_AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int NE_W      = $clog2(CELLS + 1);
    localparam int LVL_W     = (MAX_LEVEL > 0) ? $clog2(MAX_LEVEL + 1) : 1;
    localparam int QW        = MAX_LEVEL + 1;
    localparam int CW        = (MAX_LEVEL > 0) ? MAX_LEVEL : 1;
    localparam int SW        = POS_W + MAX_LEVEL;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    // Configuration reset values.
    localparam logic [LEVELS_W-1:0] LEVELS_RESET = 2'd2;
    localparam logic [POS_W-1:0]    WIDTH_RESET  = 12'd640;
    localparam logic [POS_W-1:0]    HEIGHT_RESET = 12'd480;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [POS_W-1:0]      x_pos;
        logic [POS_W-1:0]      y_pos;
        logic [WORD_W-1:0]     word;
        logic [CELL_REQ_W-1:0] cell_req;
    } sph_in_t;

    typedef struct packed {
        logic [OUT_W-1:0]      count;
        logic [OUT_W-1:0]      cell_total;
        logic [NONEMPTY_W-1:0] nonempty_cells;
    } sph_out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_READ,
        ST_WRITE,
        ST_RDATA
    } sph_state_t;

    typedef struct packed {
        logic take;
        logic clr_start;
        logic clr_step;
        logic add_start;
        logic addr_load;
        logic mem_read;
        logic mem_write;
        logic rd_issue;
        logic out_load;
    } sph_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            word_ok;
        logic            clr_last;
        logic            div_done;
        logic            last_level;
        logic            out_free;
    } sph_stat_t;

    // Saturate a stored count to the output field width.
    function automatic logic [OUT_W-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        if (wide > 32'hFFFF) begin
            return {OUT_W{1'b1}};
        end
        return OUT_W'(wide);
    endfunction

endpackage

>>> rtl/sph_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sph_ram: generic single-write, single-read memory
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module sph_ram #(
    parameter int  DATA_W = 16,
    parameter int  DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/sph_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sph_div: grid coordinate divider
// Restoring division of a position by the level span, one quotient bit per
// cycle, with the result clamped to the last cell of the level.
// ----------------------------------------------------------------------------
module sph_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [sph_pkg::POS_W-1:0]  pos,
    input  logic [sph_pkg::POS_W-1:0]  size,
    input  logic [sph_pkg::LVL_W-1:0]  level,
    output logic                       done,
    output logic [sph_pkg::CW-1:0]     coord
);
    import sph_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [LVL_W-1:0] k_reg;
    logic [LVL_W-1:0] lvl_reg;
    logic [POS_W-1:0] rem_reg;
    logic [SW-1:0]    div_reg;
    logic [QW-1:0]    q_reg;

    logic [POS_W-1:0] span_raw;
    logic [POS_W-1:0] span;
    logic             ge;
    logic [QW-1:0]    bins_m1;

    // A span of zero is taken as one, so a position past the last cell is
    // clamped to the last cell.
    assign span_raw = size >> level;
    assign span     = (span_raw == '0) ? POS_W'(1) : span_raw;
    assign ge       = SW'(rem_reg) >= div_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && k_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // The first step tests the bit one above the last cell; a set bit there
    // means the quotient is past the grid and the clamp takes over.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= pos;
            div_reg <= SW'(span) << level;
            q_reg   <= '0;
            k_reg   <= level;
            lvl_reg <= level;
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - div_reg[POS_W-1:0];
            end
            div_reg <= div_reg >> 1;
            q_reg   <= (q_reg << 1) | QW'(ge);
            k_reg   <= k_reg - 1'b1;
        end
    end

    assign bins_m1 = (QW'(1) << lvl_reg) - QW'(1);
    assign coord   = CW'((q_reg > bins_m1) ? bins_m1 : q_reg);
    assign done    = done_reg;

endmodule

>>> rtl/sph_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sph_ctrl: histogram controller
// Sequences the clearing pass, the per-level update of an add and the
// lookup of a read.
// ----------------------------------------------------------------------------
module sph_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sph_pkg::sph_stat_t stat,
    output sph_pkg::sph_cmd_t  cmd
);
    import sph_pkg::*;

    sph_state_t state_reg;
    sph_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (stat.op)
                    OP_ADD: begin
                        if (stat.word_ok) begin
                            cmd.add_start = 1'b1;
                            state_next    = ST_DIV;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    OP_READ: begin
                        cmd.rd_issue = 1'b1;
                        state_next   = ST_RDATA;
                    end
                    OP_CLEAR: begin
                        cmd.clr_start = 1'b1;
                        state_next    = ST_CLEAR;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    cmd.addr_load = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ: begin
                cmd.mem_read = 1'b1;
                state_next   = ST_WRITE;
            end
            ST_WRITE: begin
                cmd.mem_write = 1'b1;
                state_next    = stat.last_level ? ST_IDLE : ST_DIV;
            end
            ST_RDATA: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/sph_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sph_dp: histogram datapath
// Configuration registers, item register, coordinate dividers, cell and bin
// addressing, count and total memories with saturating update, and the
// result register.
// ----------------------------------------------------------------------------
module sph_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sph_pkg::sph_cmd_t             cmd,
    output sph_pkg::sph_stat_t            stat,
    input  sph_pkg::sph_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output sph_pkg::sph_out_t             m_data,
    input  logic                          cfg_we,
    input  logic [sph_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sph_pkg::CFG_W-1:0]     cfg_wdata
);
    import sph_pkg::*;

    logic [LEVELS_W-1:0]   levels_reg;
    logic [POS_W-1:0]      width_reg;
    logic [POS_W-1:0]      height_reg;
    sph_in_t               item_reg;
    logic [LVL_W-1:0]      lvl_reg;
    logic [TOT_AW-1:0]     off_reg;
    logic [BIN_AW-1:0]     addr_reg;
    logic [TOT_AW-1:0]     cell_reg;
    logic [BIN_AW-1:0]     clr_ptr_reg;
    logic [NE_W-1:0]       nonempty_reg;
    sph_out_t              out_reg;
    logic                  out_valid_reg;

    logic [LVL_W-1:0]      top_level;
    logic                  last_level;
    logic                  div_start;
    logic [LVL_W-1:0]      div_level;
    logic                  x_done;
    logic                  y_done;
    logic [CW-1:0]         col;
    logic [CW-1:0]         row;
    logic [TOT_AW-1:0]     cell_now;
    logic [BIN_AW-1:0]     bin_addr_now;
    logic                  word_ok;
    logic                  cell_ok;
    logic [TOT_AW-1:0]     rd_cell;
    logic [BIN_AW-1:0]     rd_bin_addr;
    logic                  tot_clr;
    logic [COUNT_BITS-1:0] bin_rdata;
    logic [COUNT_BITS-1:0] tot_rdata;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [COUNT_BITS-1:0] tot_inc;
    logic                  bin_wr_en;
    logic [BIN_AW-1:0]     bin_wr_addr;
    logic [COUNT_BITS-1:0] bin_wr_data;
    logic                  bin_rd_en;
    logic [BIN_AW-1:0]     bin_rd_addr;
    logic                  tot_wr_en;
    logic [TOT_AW-1:0]     tot_wr_addr;
    logic [COUNT_BITS-1:0] tot_wr_data;
    logic [TOT_AW-1:0]     tot_rd_addr;
    sph_out_t              out_next;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg <= LEVELS_RESET;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LEVELS: levels_reg <= cfg_wdata[LEVELS_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_wdata[POS_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_wdata[POS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            item_reg <= s_data;
        end
    end

    assign word_ok = 32'(item_reg.word) < WORDS;
    assign cell_ok = 32'(item_reg.cell_req) < CELLS;

    // Level walk of an add.
    assign top_level  = (32'(levels_reg) > MAX_LEVEL) ? LVL_W'(MAX_LEVEL)
                                                      : LVL_W'(levels_reg);
    assign last_level = lvl_reg == top_level;
    assign div_start  = cmd.add_start || (cmd.mem_write && !last_level);
    assign div_level  = cmd.add_start ? '0 : lvl_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (cmd.add_start) begin
            lvl_reg <= '0;
            off_reg <= '0;
        end else if (cmd.mem_write && !last_level) begin
            lvl_reg <= lvl_reg + 1'b1;
            off_reg <= off_reg + (TOT_AW'(1) << {lvl_reg, 1'b0});
        end
    end

    sph_div u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .pos     (item_reg.x_pos),
        .size    (width_reg),
        .level   (div_level),
        .done    (x_done),
        .coord   (col)
    );

    sph_div u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .pos     (item_reg.y_pos),
        .size    (height_reg),
        .level   (div_level),
        .done    (y_done),
        .coord   (row)
    );

    assign cell_now     = off_reg + TOT_AW'(col) + (TOT_AW'(row) << lvl_reg);
    assign bin_addr_now = BIN_AW'(cell_now) * BIN_AW'(WORDS) + BIN_AW'(item_reg.word);

    always_ff @(posedge aclk) begin
        if (cmd.addr_load) begin
            addr_reg <= bin_addr_now;
            cell_reg <= cell_now;
        end
    end

    // Read lookup; an out-of-range cell or word reads entry zero of the affected memory and is masked.
    assign rd_cell     = cell_ok ? TOT_AW'(item_reg.cell_req) : '0;
    assign rd_bin_addr = (cell_ok && word_ok)
                       ? BIN_AW'(rd_cell) * BIN_AW'(WORDS) + BIN_AW'(item_reg.word)
                       : '0;

    // Clearing pass pointer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_ptr_reg <= '0;
        end else if (cmd.clr_start) begin
            clr_ptr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_ptr_reg <= clr_ptr_reg + 1'b1;
        end
    end

    assign tot_clr = cmd.clr_step && (32'(clr_ptr_reg) < CELLS);

    // Saturating increments of the values read in the previous cycle.
    assign cnt_inc = (&bin_rdata) ? bin_rdata : bin_rdata + 1'b1;
    assign tot_inc = (&tot_rdata) ? tot_rdata : tot_rdata + 1'b1;

    assign bin_wr_en   = cmd.clr_step || cmd.mem_write;
    assign bin_wr_addr = cmd.clr_step ? clr_ptr_reg : addr_reg;
    assign bin_wr_data = cmd.clr_step ? '0 : cnt_inc;
    assign bin_rd_en   = cmd.mem_read || cmd.rd_issue;
    assign bin_rd_addr = cmd.rd_issue ? rd_bin_addr : addr_reg;

    assign tot_wr_en   = tot_clr || cmd.mem_write;
    assign tot_wr_addr = cmd.clr_step ? TOT_AW'(clr_ptr_reg) : cell_reg;
    assign tot_wr_data = cmd.clr_step ? '0 : tot_inc;
    assign tot_rd_addr = cmd.rd_issue ? rd_cell : cell_reg;

    sph_ram #(
        .DATA_W (COUNT_BITS),
        .DEPTH  (BIN_DEPTH)
    ) u_bins (
        .aclk    (aclk),
        .wr_en   (bin_wr_en),
        .wr_addr (bin_wr_addr),
        .wr_data (bin_wr_data),
        .rd_en   (bin_rd_en),
        .rd_addr (bin_rd_addr),
        .rd_data (bin_rdata)
    );

    sph_ram #(
        .DATA_W (COUNT_BITS),
        .DEPTH  (CELLS)
    ) u_totals (
        .aclk    (aclk),
        .wr_en   (tot_wr_en),
        .wr_addr (tot_wr_addr),
        .wr_data (tot_wr_data),
        .rd_en   (bin_rd_en),
        .rd_addr (tot_rd_addr),
        .rd_data (tot_rdata)
    );

    // A cell becomes nonempty the first time its total leaves zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nonempty_reg <= '0;
        end else if (cmd.clr_start) begin
            nonempty_reg <= '0;
        end else if (cmd.mem_write && tot_rdata == '0) begin
            nonempty_reg <= nonempty_reg + 1'b1;
        end
    end

    // Result register.
    always_comb begin
        out_next.count          = sat_out((cell_ok && word_ok) ? bin_rdata : '0);
        out_next.cell_total     = sat_out(cell_ok ? tot_rdata : '0);
        out_next.nonempty_cells = NONEMPTY_W'(nonempty_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        stat.op         = item_reg.op;
        stat.word_ok    = word_ok;
        stat.clr_last   = clr_ptr_reg == BIN_AW'(BIN_DEPTH - 1);
        stat.div_done   = x_done && y_done;
        stat.last_level = last_level;
        stat.out_free   = !out_valid_reg || m_ready;
    end

endmodule

>>> rtl/spatial_pyramid_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_pyramid_histogram: spatial pyramid bag-of-words histogram
// Counts keypoints per pyramid cell and visual word, keeps saturating cell
// totals and a nonempty-cell count, and answers bin lookups.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                            Direction  Carries
//  -------   -------------------------------  ---------  -----------------------
//  input     s_valid, s_ready, s_data         in         add, read or clear
//  result    m_valid, m_ready, m_data         out        count, total, nonempty
//  config    cfg_we, cfg_index, cfg_wdata     in         levels, width, height
//
// An add walks every level from 0 to the top one: three levels at the default
// setting, four at most. The per-level cost is set by the bit-serial coordinate
// dividers (level + 1 steps) and the read-modify-write of the registered-read
// count and total memories. A clear request starts a new clearing pass.
// After reset, and after every clear request, a clearing pass writes zero to
// all 87040 count entries, one per cycle, with s_ready held low; configuration
// writes are still taken during it.
// The result register lets the block take its next request while a lookup
// result waits on m_ready; a read only stalls if that register is still full.
//
module spatial_pyramid_histogram (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  sph_pkg::sph_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output sph_pkg::sph_out_t             m_data,
    input  logic                          cfg_we,
    input  logic [sph_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sph_pkg::CFG_W-1:0]     cfg_wdata
);
    import sph_pkg::*;

    // The controller sees only s_valid and the status bundle; all storage and
    // arithmetic but its state register sit in the datapath.
    sph_cmd_t  cmd;
    sph_stat_t stat;

    sph_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    sph_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

>>> bench/sph_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sph_checker: lookup result checker for the spatial pyramid histogram
// Mirrors the histogram from the accepted requests and configuration writes
// and compares each lookup result with the oldest predicted lookup.
// ----------------------------------------------------------------------------
module sph_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  sph_pkg::sph_in_t              s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  sph_pkg::sph_out_t             m_data,
    input  logic                          cfg_we,
    input  logic [sph_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sph_pkg::CFG_W-1:0]     cfg_wdata,
    output int                            mismatches,
    output int                            outstanding
);
    import sph_pkg::*;

    logic [COUNT_BITS-1:0] bin_store [BIN_DEPTH];
    logic [COUNT_BITS-1:0] cell_sum  [CELLS];
    int unsigned           filled_cells;
    logic [LEVELS_W-1:0]   top_level;
    logic [POS_W-1:0]      img_width;
    logic [POS_W-1:0]      img_height;
    sph_out_t              lookup_q [$];

    // Grid coordinate along one axis; a span of zero counts as one pixel.
    function automatic int unsigned grid_slot(input logic [POS_W-1:0] pos,
                                              input logic [POS_W-1:0] extent,
                                              input int unsigned lv);
        int unsigned span;
        int unsigned slot;
        span = 32'(extent) >> lv;
        if (span == 0) begin
            span = 1;
        end
        slot = 32'(pos) / span;
        if (slot >= (32'd1 << lv)) begin
            slot = (32'd1 << lv) - 1;
        end
        return slot;
    endfunction

    function automatic void wipe_histogram();
        for (int i = 0; i < BIN_DEPTH; i++) begin
            bin_store[i] = '0;
        end
        for (int i = 0; i < CELLS; i++) begin
            cell_sum[i] = '0;
        end
        filled_cells = 0;
    endfunction

    function automatic void record_keypoint(input sph_in_t req);
        int unsigned last_lv;
        int unsigned base;
        int unsigned cell_idx;
        int unsigned bin_idx;
        last_lv = (top_level > MAX_LEVEL) ? MAX_LEVEL : top_level;
        base = 0;
        if (32'(req.word) >= WORDS) begin
            return;
        end
        for (int unsigned lv = 0; lv <= last_lv; lv++) begin
            cell_idx = base + grid_slot(req.x_pos, img_width, lv)
                     + (grid_slot(req.y_pos, img_height, lv) << lv);
            if (cell_idx < CELLS) begin
                bin_idx = cell_idx * WORDS + 32'(req.word);
                if (bin_store[bin_idx] != '1) begin
                    bin_store[bin_idx] = bin_store[bin_idx] + 1'b1;
                end
                if (cell_sum[cell_idx] == '0) begin
                    filled_cells++;
                end
                if (cell_sum[cell_idx] != '1) begin
                    cell_sum[cell_idx] = cell_sum[cell_idx] + 1'b1;
                end
            end
            base += 1 << (2 * lv);
        end
    endfunction

    function automatic logic [OUT_W-1:0] clamp_out(input logic [COUNT_BITS-1:0] v);
        if (64'(v) >= (64'd1 << OUT_W)) begin
            return '1;
        end
        return OUT_W'(v);
    endfunction

    function automatic sph_out_t predict_lookup(input sph_in_t req);
        sph_out_t res;
        res = '0;
        if (32'(req.cell_req) < CELLS) begin
            res.cell_total = clamp_out(cell_sum[req.cell_req]);
            if (32'(req.word) < WORDS) begin
                res.count = clamp_out(bin_store[32'(req.cell_req) * WORDS + 32'(req.word)]);
            end
        end
        res.nonempty_cells = NONEMPTY_W'(filled_cells);
        return res;
    endfunction

    // Results are taken before requests, so a result can never be matched
    // against a lookup accepted at the same edge.
    always @(posedge aclk) begin : monitor
        sph_out_t want;
        if (!aresetn) begin
            wipe_histogram();
            top_level  = LEVELS_RESET;
            img_width  = WIDTH_RESET;
            img_height = HEIGHT_RESET;
            lookup_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (lookup_q.size() == 0) begin
                    $error("lookup result %h with no lookup outstanding", m_data);
                    mismatches++;
                end else begin
                    want = lookup_q.pop_front();
                    if (m_data.count !== want.count) begin
                        $error("count: expected %0d, actual %0d", want.count, m_data.count);
                        mismatches++;
                    end
                    if (m_data.cell_total !== want.cell_total) begin
                        $error("cell_total: expected %0d, actual %0d",
                               want.cell_total, m_data.cell_total);
                        mismatches++;
                    end
                    if (m_data.nonempty_cells !== want.nonempty_cells) begin
                        $error("nonempty_cells: expected %0d, actual %0d",
                               want.nonempty_cells, m_data.nonempty_cells);
                        mismatches++;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LEVELS: top_level  = cfg_wdata[LEVELS_W-1:0];
                    CFG_WIDTH:  img_width  = cfg_wdata[POS_W-1:0];
                    CFG_HEIGHT: img_height = cfg_wdata[POS_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_data.op)
                    OP_ADD:   record_keypoint(s_data);
                    OP_READ:  lookup_q.insert(lookup_q.size(), predict_lookup(s_data));
                    OP_CLEAR: wipe_histogram();
                    default: ;
                endcase
            end
        end
        outstanding <= lookup_q.size();
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: spatial pyramid histogram bench
// Drives directed and random add, lookup and clear requests through a series
// of image and level settings, with random idling on both channels, and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
    import sph_pkg::*;

    // The clearing pass after reset and after each clear request writes all
    // 87040 count entries with nothing accepted, so the quiet limit sits well
    // above its length.
    localparam int IDLE_LIMIT    = 400000;
    // Long receiver hold-off used to back the block up into its input.
    localparam int HOLD_CYCLES   = 400;
    // Covers the longest add with room to spare.
    localparam int SETTLE_CYCLES = 40;
    // The one op code the block ignores.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    sph_in_t              s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    sph_out_t             m_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int mismatches;
    int outstanding;

    // Idling rates in percent, set per phase by the stimulus process.
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    // The stimulus raises the ticket; the receiver serves it with a long stall.
    int hold_ticket = 0;
    int hold_served = 0;
    int quiet_cycles = 0;

    // Current setting, kept so that most random requests land inside the image
    // and inside the cells that the current levels actually use.
    int unsigned       cur_levels = LEVELS_RESET;
    int unsigned       cur_width  = WIDTH_RESET;
    int unsigned       cur_height = HEIGHT_RESET;
    // A small pool of visual words per phase makes lookups hit filled bins.
    logic [WORD_W-1:0] word_pool [8];

    spatial_pyramid_histogram DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    sph_checker lookup_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side. Each cycle m_ready is drawn against the current stall
    // rate. When a hold-off is requested the receiver refuses results for a
    // long stretch, counted here, so that the result register fills and the
    // block stops taking requests.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_ticket != hold_served) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_served++;
            end
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog: any accepted request or result restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic sph_in_t make_req(input logic [OP_W-1:0] op,
                                         input int unsigned x, y, word, cell_no);
        sph_in_t item;
        item.op       = op;
        item.x_pos    = POS_W'(x);
        item.y_pos    = POS_W'(y);
        item.word     = WORD_W'(word);
        item.cell_req = CELL_REQ_W'(cell_no);
        return item;
    endfunction

    // Mostly adds and lookups, a few requests with the unused code. Most
    // positions fall inside the image, a quarter anywhere in the 12-bit
    // range so that clamping to the last cell gets exercised. Most lookups
    // address cells in use; some reach past the end of the store.
    function automatic sph_in_t random_request();
        sph_in_t     item;
        int unsigned pick;
        int unsigned cells_used;
        cells_used = ((1 << (2 * (cur_levels + 1))) - 1) / 3;
        pick = $urandom_range(99);
        item.op = (pick < 58) ? OP_ADD : (pick < 95) ? OP_READ : OP_UNUSED;
        item.x_pos = ($urandom_range(3) == 0) ? POS_W'($urandom)
                                              : POS_W'($urandom_range(cur_width));
        item.y_pos = ($urandom_range(3) == 0) ? POS_W'($urandom)
                                              : POS_W'($urandom_range(cur_height));
        item.word = ($urandom_range(4) == 0) ? WORD_W'($urandom)
                                             : word_pool[$urandom_range(7)];
        item.cell_req = ($urandom_range(6) == 0) ? CELL_REQ_W'($urandom)
                                                 : CELL_REQ_W'($urandom_range(cells_used - 1));
        return item;
    endfunction

    // Offer one request and hold it until the block takes it. Idle cycles
    // before the request follow the sender's idle rate; valid is only lowered
    // on those cycles, never between two back-to-back requests.
    task automatic send_request(input sph_in_t item);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering, wait for every outstanding lookup to come back, then
    // give a trailing add time to finish before anything else happens.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all three registers on consecutive cycles. Only call when idle.
    task automatic apply_setting(input int unsigned lv, w, h);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LEVELS;
        cfg_wdata <= CFG_W'(lv);
        @(posedge aclk);
        cfg_index <= CFG_WIDTH;
        cfg_wdata <= CFG_W'(w);
        @(posedge aclk);
        cfg_index <= CFG_HEIGHT;
        cfg_wdata <= CFG_W'(h);
        @(posedge aclk);
        cfg_we     <= 1'b0;
        cur_levels = lv;
        cur_width  = w;
        cur_height = h;
    endtask

    // One random phase: new setting, new word pool, an optional clear request
    // first, an optional burst of lookups under a long receiver hold-off, then
    // random requests, and finally a pause until every result is back.
    task automatic run_phase(input int unsigned lv, w, h, input int idle, stall,
                             input bit wipe, squeeze, input int items);
        sph_in_t item;
        apply_setting(lv, w, h);
        sender_idle_pct    = idle;
        receiver_stall_pct = stall;
        for (int i = 0; i < 8; i++) begin
            word_pool[i] = WORD_W'($urandom);
        end
        word_pool[0] = '0;
        word_pool[1] = '1;
        if (wipe) begin
            send_request(make_req(OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
        end
        if (squeeze) begin
            hold_ticket++;
            for (int i = 0; i < 16; i++) begin
                item    = random_request();
                item.op = OP_READ;
                send_request(item);
            end
        end
        for (int i = 0; i < items; i++) begin
            send_request(random_request());
        end
        settle();
    endtask

    initial begin
        // Reset first; the block then runs its clearing pass with
        // s_ready low, and the first request simply waits for it.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests at the reset setting: 640 by 480, levels 0 to 2,
        // so cells 0 to 20 are in use.
        send_request(make_req(OP_READ, 0, 0, 0, 0));              // empty store
        send_request(make_req(OP_ADD, 0, 0, 0, 0));               // top-left corner
        send_request(make_req(OP_ADD, 4095, 4095, 1023, 127));    // far past the image
        send_request(make_req(OP_ADD, 639, 479, 1023, 0));        // last pixel
        send_request(make_req(OP_ADD, 320, 240, 5, 0));
        send_request(make_req(OP_ADD, 319, 239, 5, 0));
        send_request(make_req(OP_READ, 0, 0, 0, 0));
        send_request(make_req(OP_READ, 4095, 4095, 1023, 0));
        send_request(make_req(OP_READ, 0, 0, 1023, 20));          // last cell in use
        send_request(make_req(OP_READ, 0, 0, 5, 4));
        send_request(make_req(OP_READ, 0, 0, 1023, 84));          // last cell of the store
        send_request(make_req(OP_READ, 0, 0, 0, 85));             // first cell past it
        send_request(make_req(OP_READ, 0, 0, 1023, 127));
        // The unused code must leave the store alone.
        send_request(make_req(OP_UNUSED, 4095, 4095, 1023, 127));
        send_request(make_req(OP_READ, 0, 0, 1023, 0));
        send_request(make_req(OP_CLEAR, 0, 0, 0, 0));
        send_request(make_req(OP_READ, 0, 0, 0, 0));              // zero after the clear
        send_request(make_req(OP_ADD, 2730, 1365, 682, 42));      // alternating bits
        send_request(make_req(OP_READ, 1365, 2730, 682, 0));
        settle();

        // A 5 by 3 image at level 3 gives spans of zero, which count as one
        // pixel, so large coordinates clamp to the last column or row.
        apply_setting(3, 5, 3);
        send_request(make_req(OP_ADD, 4095, 0, 1, 0));
        send_request(make_req(OP_ADD, 1, 2, 1, 0));
        send_request(make_req(OP_READ, 0, 0, 1, 28));
        send_request(make_req(OP_READ, 0, 0, 1, 38));
        send_request(make_req(OP_READ, 0, 0, 1, 8));
        settle();

        // Random phases: idling modes rotate through none, sender only,
        // receiver only and both, across several settings including levels 0 and 3
        // and the largest width and height.
        run_phase(3, 4095, 4095, 0, 0, 0, 0, 240);
        run_phase(0, 8, 8, 55, 0, 0, 0, 220);
        run_phase(3, 8, 8, 0, 55, 1, 0, 240);
        run_phase(1, 1000, 300, 30, 30, 0, 0, 220);
        run_phase(3, 5, 3, 0, 0, 0, 1, 200);
        run_phase(2, 640, 480, 55, 0, 1, 0, 240);
        run_phase($urandom_range(3), $urandom_range(4095, 8), $urandom_range(4095, 8),
                  0, 55, 0, 0, 240);
        run_phase(3, 4095, 8, 30, 30, 0, 0, 220);

        if (mismatches == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> spatial_pyramid_histogram.f
rtl/sph_pkg.sv
rtl/sph_ram.sv
rtl/sph_div.sv
rtl/sph_ctrl.sv
rtl/sph_dp.sv
rtl/spatial_pyramid_histogram.sv
bench/sph_checker.sv
bench/testbench.sv
